// ----- rtl/drp_pkg.sv -----
package drp_pkg;

   localparam int MAX_FRAME_BYTES_DEF = 2048;
   localparam int PAYLOAD_OFFSET_DEF  = 42;

   // frame layout, relative to the start of the udp payload
   localparam int SRC_PORT_BACK  = 7;
   localparam int XID_OFFSET     = 4;
   localparam int YIADDR_OFFSET  = 16;
   localparam int OPTIONS_START  = 240;
   localparam int MSG_VALUE_BACK = 242;
   localparam int MIN_FRAME_BYTES = 70;

   localparam logic [7:0] SERVER_PORT_LOW = 8'd67;
   localparam logic [7:0] BOOTREPLY       = 8'd2;
   localparam logic [7:0] OPT_MSG_TYPE    = 8'd53;
   localparam logic [7:0] MSG_OFFER       = 8'h02;
   localparam logic [7:0] MSG_ACK         = 8'h05;
   localparam logic [7:0] OPT_SUBNET      = 8'd1;
   localparam logic [7:0] OPT_ROUTER      = 8'd3;
   localparam logic [7:0] OPT_DNS         = 8'd6;
   localparam logic [7:0] OPT_SERVER_ID   = 8'd54;
   localparam logic [7:0] OPT_LEASE       = 8'd51;
   localparam logic [31:0] LEASE_SCALE    = 32'd1000;

   typedef logic [1:0] kind_type;
   localparam kind_type KIND_NONE    = 2'd0;
   localparam kind_type KIND_OFFER   = 2'd1;
   localparam kind_type KIND_ACK     = 2'd2;
   localparam kind_type KIND_PENDING = 2'd3;

   localparam int NUM_SLOTS = 6;
   typedef logic [2:0] slot_type;
   localparam slot_type SLOT_YIADDR = 3'd0;
   localparam slot_type SLOT_SUBNET = 3'd1;
   localparam slot_type SLOT_ROUTER = 3'd2;
   localparam slot_type SLOT_DNS    = 3'd3;
   localparam slot_type SLOT_SERVER = 3'd4;
   localparam slot_type SLOT_LEASE  = 3'd5;
   localparam slot_type SLOT_NONE   = 3'd6;

   typedef logic [NUM_SLOTS-1:0][31:0] slot_values_type;

   typedef struct packed {
      logic       first;
      logic       opt_step;
      logic       yi_en;
      logic [1:0] yi_lane;
   } frame_status_type;

   typedef struct packed {
      logic       en;
      slot_type   slot;
      logic [1:0] lane;
      logic       mul;
   } capture_type;

   function automatic slot_type slot_of(input logic [7:0] code);
      slot_type s;
      case (code)
         OPT_SUBNET:    s = SLOT_SUBNET;
         OPT_ROUTER:    s = SLOT_ROUTER;
         OPT_DNS:       s = SLOT_DNS;
         OPT_SERVER_ID: s = SLOT_SERVER;
         OPT_LEASE:     s = SLOT_LEASE;
         default:       s = SLOT_NONE;
      endcase
      return s;
   endfunction

endpackage

// ----- rtl/drp_frame_check.sv -----
module drp_frame_check import drp_pkg::*; #(
   parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF,
   parameter int PAYLOAD_OFFSET  = PAYLOAD_OFFSET_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             fire,
   input  logic             last,
   input  logic [7:0]       frame_byte,
   input  logic [31:0]      transaction_id,
   output frame_status_type status,
   output kind_type         reply_kind
);

   localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic             header_ok_ff, header_ok_in;
   kind_type         kind_ff, kind_in;
   logic [31:0]      pos_wide, xid_off, yi_off;
   logic             in_frame;
   logic [7:0]       want;

   always_comb begin
      pos_wide = 32'(pos_ff);
      in_frame = pos_wide < 32'(MAX_FRAME_BYTES);
      xid_off  = pos_wide - 32'(PAYLOAD_OFFSET + XID_OFFSET);
      yi_off   = pos_wide - 32'(PAYLOAD_OFFSET + YIADDR_OFFSET);
      want     = 8'(transaction_id >> {~xid_off[1:0], 3'b000});

      status.first    = (pos_ff == '0);
      status.opt_step = in_frame && pos_wide >= 32'(PAYLOAD_OFFSET + OPTIONS_START);
      status.yi_en    = in_frame && pos_wide >= 32'(PAYLOAD_OFFSET + YIADDR_OFFSET)
                        && pos_wide <= 32'(PAYLOAD_OFFSET + YIADDR_OFFSET + 3);
      status.yi_lane  = yi_off[1:0];

      pos_in       = pos_ff;
      header_ok_in = header_ok_ff;
      kind_in      = kind_ff;

      if (in_frame) begin
         if (pos_wide == 32'(PAYLOAD_OFFSET - SRC_PORT_BACK) && frame_byte != SERVER_PORT_LOW)
            header_ok_in = 1'b0;
         if (pos_wide == 32'(PAYLOAD_OFFSET) && frame_byte != BOOTREPLY)
            header_ok_in = 1'b0;
         if (pos_wide >= 32'(PAYLOAD_OFFSET + XID_OFFSET)
             && pos_wide <= 32'(PAYLOAD_OFFSET + XID_OFFSET + 3) && frame_byte != want)
            header_ok_in = 1'b0;
         if (pos_wide == 32'(PAYLOAD_OFFSET + OPTIONS_START) && frame_byte == OPT_MSG_TYPE)
            kind_in = KIND_PENDING;
         if (pos_wide == 32'(PAYLOAD_OFFSET + MSG_VALUE_BACK) && kind_ff == KIND_PENDING) begin
            if (frame_byte == MSG_OFFER)
               kind_in = KIND_OFFER;
            else if (frame_byte == MSG_ACK)
               kind_in = KIND_ACK;
            else
               kind_in = KIND_NONE;
         end
         pos_in = pos_ff + POS_W'(1);
      end

      if (header_ok_in && pos_wide >= 32'(MIN_FRAME_BYTES - 1)
          && (kind_in == KIND_OFFER || kind_in == KIND_ACK))
         reply_kind = kind_in;
      else
         reply_kind = KIND_NONE;

      if (last) begin
         pos_in       = '0;
         header_ok_in = 1'b1;
         kind_in      = KIND_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         header_ok_ff <= 1'b1;
         kind_ff      <= KIND_NONE;
      end else if (fire) begin
         pos_ff       <= pos_in;
         header_ok_ff <= header_ok_in;
         kind_ff      <= kind_in;
      end
   end

endmodule

// ----- rtl/drp_option_walk.sv -----
module drp_option_walk import drp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        step,
   input  logic        frame_end,
   input  logic [7:0]  frame_byte,
   output capture_type cap
);

   typedef enum logic [2:0] {
      PHASE_CODE = 3'b001,
      PHASE_LEN  = 3'b010,
      PHASE_DATA = 3'b100
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [7:0]  code_ff, code_in;
   logic [7:0]  rem_ff, rem_in;
   logic [2:0]  idx_ff, idx_in;
   logic [7:0]  rem_dec;
   slot_type    slot;

   always_comb begin
      phase_in = phase_ff;
      code_in  = code_ff;
      rem_in   = rem_ff;
      idx_in   = idx_ff;
      rem_dec  = rem_ff - 8'd1;
      slot     = slot_of(code_ff);
      cap      = '0;

      if (step) begin
         case (phase_ff)
            PHASE_CODE: begin
               code_in  = frame_byte;
               phase_in = PHASE_LEN;
            end
            PHASE_LEN: begin
               rem_in   = frame_byte;
               idx_in   = 3'd0;
               phase_in = (frame_byte != 8'd0) ? PHASE_DATA : PHASE_CODE;
            end
            PHASE_DATA: begin
               if (idx_ff < 3'd4) begin
                  cap.en   = (slot != SLOT_NONE);
                  cap.slot = slot;
                  cap.lane = idx_ff[1:0];
                  cap.mul  = (slot == SLOT_LEASE) && (idx_ff == 3'd3 || rem_dec == 8'd0);
                  idx_in   = idx_ff + 3'd1;
               end
               rem_in = rem_dec;
               if (rem_dec == 8'd0)
                  phase_in = PHASE_CODE;
            end
            default: phase_in = PHASE_CODE;
         endcase
      end

      if (frame_end) begin
         // lease cut off by the end of the frame
         if (phase_in == PHASE_DATA && code_in == OPT_LEASE
             && idx_in >= 3'd1 && idx_in <= 3'd3)
            cap.mul = 1'b1;
         phase_in = PHASE_CODE;
         code_in  = 8'd0;
         rem_in   = 8'd0;
         idx_in   = 3'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_CODE;
         code_ff  <= 8'd0;
         rem_ff   <= 8'd0;
         idx_ff   <= 3'd0;
      end else begin
         phase_ff <= phase_in;
         code_ff  <= code_in;
         rem_ff   <= rem_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

// ----- rtl/drp_value_store.sv -----
module drp_value_store import drp_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            fire,
   input  logic            first,
   input  logic [7:0]      frame_byte,
   input  logic            yi_en,
   input  logic [1:0]      yi_lane,
   input  capture_type     cap,
   input  logic            commit,
   output slot_values_type committed_next
);

   slot_values_type shadow_ff, shadow_in;
   slot_values_type committed_ff, committed_in;
   logic [31:0]     base, placed, val;
   logic            wr;
   logic [1:0]      lane;

   always_comb begin
      base   = '0;
      placed = '0;
      val    = '0;
      wr     = 1'b0;
      lane   = 2'd0;
      for (int s = 0; s < NUM_SLOTS; s++) begin
         base = first ? committed_ff[s] : shadow_ff[s];
         if (s == int'(SLOT_YIADDR)) begin
            wr   = yi_en;
            lane = yi_lane;
         end else begin
            wr   = cap.en && (cap.slot == slot_type'(s));
            lane = cap.lane;
         end
         placed = {frame_byte, 24'd0} >> {lane, 3'b000};
         val    = base;
         if (wr)
            val = (lane == 2'd0) ? placed : (base | placed);
         if (s == int'(SLOT_LEASE) && cap.mul)
            val = 32'(val * LEASE_SCALE);
         shadow_in[s]    = fire ? val : shadow_ff[s];
         committed_in[s] = commit ? shadow_in[s] : committed_ff[s];
      end
   end

   assign committed_next = committed_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         shadow_ff    <= '0;
         committed_ff <= '0;
      end else begin
         shadow_ff    <= shadow_in;
         committed_ff <= committed_in;
      end
   end

endmodule

// ----- rtl/dhcp_reply_parser.sv -----
// Parses received Ethernet frames, one byte per word, for DHCP offer and ack
// replies addressed to the exchange whose xid is held in the csr register.
// A byte is taken every cycle while req_tready is high; the last byte of a
// frame passes the input register, then the result register is loaded with
// the frame's result, and that byte waits in the input register only while the
// previous result has not yet been taken. Every frame gives one result word:
// the reply kind on tuser and the committed address, mask, gateway, dns,
// server and lease-in-milliseconds values on tdata, updated only by offers.
module dhcp_reply_parser import drp_pkg::*; #(
   parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF,
   parameter int PAYLOAD_OFFSET  = PAYLOAD_OFFSET_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // frame_byte
   input  logic         req_tlast,   // last_byte
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // offered_address, subnet_mask, gateway_address, dns_address,
   // server_address, lease_millis
   output logic [191:0] rsp_tdata,
   output logic [1:0]   rsp_tuser,   // reply_kind
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [31:0]  csr_wdata    // transaction_id
);

   logic             s1_valid_ff, s1_valid_in;
   logic [7:0]       s1_byte_ff;
   logic             s1_last_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [191:0]     rsp_data_ff;
   kind_type         rsp_kind_ff;
   logic [31:0]      tid_ff;
   logic             advance, fire, frame_end, commit;
   frame_status_type status;
   kind_type         reply_kind;
   capture_type      cap;
   slot_values_type  committed_next;

   assign advance    = !s1_last_ff || !rsp_valid_ff || rsp_tready;
   assign fire       = s1_valid_ff && advance;
   assign frame_end  = fire && s1_last_ff;
   assign commit     = frame_end && reply_kind == KIND_OFFER;
   assign req_tready = !s1_valid_ff || advance;
   assign csr_ready  = 1'b1;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_tready)
         s1_valid_in = req_tvalid;
      rsp_valid_in = rsp_valid_ff;
      if (frame_end)
         rsp_valid_in = 1'b1;
      else if (rsp_tready)
         rsp_valid_in = 1'b0;
   end

   drp_frame_check #(
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
      .PAYLOAD_OFFSET  (PAYLOAD_OFFSET)
   ) u_frame_check (
      .clock          (clock),
      .reset          (reset),
      .fire           (fire),
      .last           (s1_last_ff),
      .frame_byte     (s1_byte_ff),
      .transaction_id (tid_ff),
      .status         (status),
      .reply_kind     (reply_kind)
   );

   drp_option_walk u_option_walk (
      .clock      (clock),
      .reset      (reset),
      .step       (fire && status.opt_step),
      .frame_end  (frame_end),
      .frame_byte (s1_byte_ff),
      .cap        (cap)
   );

   drp_value_store u_value_store (
      .clock          (clock),
      .reset          (reset),
      .fire           (fire),
      .first          (status.first),
      .frame_byte     (s1_byte_ff),
      .yi_en          (status.yi_en),
      .yi_lane        (status.yi_lane),
      .cap            (cap),
      .commit         (commit),
      .committed_next (committed_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         tid_ff       <= 32'd0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready)
            tid_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_byte_ff <= req_tdata;
         s1_last_ff <= req_tlast;
      end
      if (frame_end) begin
         rsp_data_ff <= committed_next;
         rsp_kind_ff <= reply_kind;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;

endmodule
